@@ hdl/ucld_pkg.sv @@
// Shared types, constants and calendar helpers of the UTC clock block.
`default_nettype none
package ucld_pkg;

    localparam int unsigned QueueDepth = 2;

    localparam logic [15:0] MjdFloor  = 16'd15079;
    localparam logic [10:0] QuadDays  = 11'd1461;
    localparam logic [16:0] QuadRecip = 17'd91868;
    localparam int unsigned QuadShift = 27;
    localparam logic [17:0] WeekRecip = 18'd149797;
    localparam int unsigned WeekShift = 20;
    localparam logic [11:0] BaseYear  = 12'd1900;
    localparam logic [5:0]  ZoneUtc   = 6'd24;

    typedef logic [1:0] t_op;
    localparam t_op OP_TICK = 2'd0;
    localparam t_op OP_SET  = 2'd1;
    localparam t_op OP_READ = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  elapsed_seconds;
        logic [15:0] set_mjd;
        logic [5:0]  set_hours_bcd;
        logic [6:0]  set_minutes_bcd;
        logic [6:0]  set_seconds_bcd;
    } t_in_item;

    typedef struct packed {
        logic        time_valid;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  local_hours;
        logic [5:0]  local_minutes;
        logic [5:0]  clock_seconds;
    } t_out_item;

    typedef struct packed {
        t_op         op;
        logic [7:0]  elapsed;
        logic [15:0] mjd;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } t_cmd;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  wd;
    } t_date;

    function automatic logic [5:0] bcd_sat(input logic [6:0] v, input logic [5:0] lim);
        logic [6:0] x;
        x = 7'(v[6:4]) * 7'd10 + 7'(v[3:0]);
        bcd_sat = (x > 7'(lim)) ? lim : x[5:0];
    endfunction

    // Day offset of each month in a year that starts in March.
    function automatic logic [8:0] month_start(input logic [3:0] i);
        case (i)
            4'd0:    month_start = 9'd0;
            4'd1:    month_start = 9'd31;
            4'd2:    month_start = 9'd61;
            4'd3:    month_start = 9'd92;
            4'd4:    month_start = 9'd122;
            4'd5:    month_start = 9'd153;
            4'd6:    month_start = 9'd184;
            4'd7:    month_start = 9'd214;
            4'd8:    month_start = 9'd245;
            4'd9:    month_start = 9'd275;
            4'd10:   month_start = 9'd306;
            4'd11:   month_start = 9'd337;
            default: month_start = 9'd0;
        endcase
    endfunction

    // Years seen here stay within a few centuries of 2000.
    function automatic logic is_leap(input logic [11:0] y);
        is_leap = (y[1:0] == 2'd0) && (y != 12'd1800) && (y != 12'd1900)
                  && (y != 12'd2100) && (y != 12'd2200);
    endfunction

    function automatic logic [4:0] days_in(input logic [11:0] y, input logic [3:0] m);
        case (m)
            4'd2:    days_in = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: days_in = 5'd30;
            default: days_in = 5'd31;
        endcase
    endfunction

    function automatic t_date day_fwd(input t_date a);
        t_date      r;
        logic [5:0] d1;
        r  = a;
        d1 = 6'(a.day) + 6'd1;
        if (d1 > 6'(days_in(a.year, a.month))) begin
            r.day = 5'd1;
            if (a.month >= 4'd12) begin
                r.month = 4'd1;
                r.year  = a.year + 12'd1;
            end else begin
                r.month = a.month + 4'd1;
            end
        end else begin
            r.day = d1[4:0];
        end
        r.wd = (a.wd >= 3'd7) ? 3'd1 : a.wd + 3'd1;
        day_fwd = r;
    endfunction

    function automatic t_date day_bck(input t_date a);
        t_date r;
        r = a;
        if (a.day == 5'd1) begin
            if (a.month == 4'd1) begin
                r.month = 4'd12;
                r.year  = a.year - 12'd1;
            end else begin
                r.month = a.month - 4'd1;
            end
            r.day = days_in(r.year, r.month);
        end else begin
            r.day = a.day - 5'd1;
        end
        r.wd = (a.wd <= 3'd1) ? 3'd7 : a.wd - 3'd1;
        day_bck = r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/ucld_if.sv @@
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface ucld_in_if;
    import ucld_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

interface ucld_out_if;
    import ucld_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ hdl/utc_clock_local_date_top.sv @@
// Top level of the UTC clock with local date and time read-out.
//
//   channel   direction   contents
//   i_in      sink        mode, elapsed seconds, set MJD and BCD h:m:s
//   o_out     source      validity, local date, weekday, local h:m, seconds
//   i_cfg_*   write only  zone code in half hours (24 is UTC)
//
// Each transaction yields one result after it is accepted and has passed the
// back-end sequencer (update, multiply, divide fix-up, date, offset); a new
// command starts once the result register is free.
// The command queue lets the input side keep accepting while the back end works, until it is full.
// Reset is synchronous: clock unset, zone code 24, queue and result emptied.
`default_nettype none
module utc_clock_local_date_top #(
    parameter int unsigned QDepth = ucld_pkg::QueueDepth
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [5:0] i_cfg_wdata,
    ucld_in_if.sink         i_in,
    ucld_out_if.source      o_out
);
    import ucld_pkg::*;

    t_cmd push_cmd, head_cmd;
    logic push, full, pop, empty;

    ucld_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_cmd  (push_cmd),
        .o_push (push)
    );

    ucld_queue #(.Depth(QDepth)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    ucld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (head_cmd),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire

@@ hdl/ucld_front.sv @@
// Front end: accepts input transactions and decodes them into commands.
`default_nettype none
module ucld_front (
    ucld_in_if.sink          i_in,
    input  wire logic        i_full,
    output ucld_pkg::t_cmd   o_cmd,
    output logic             o_push
);
    import ucld_pkg::*;

    logic [5:0] hours_sat;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        case (i_in.payload.mode)
            OP_TICK: o_cmd.op = OP_TICK;
            OP_SET:  o_cmd.op = OP_SET;
            default: o_cmd.op = OP_READ;
        endcase
        hours_sat     = bcd_sat({1'b0, i_in.payload.set_hours_bcd}, 6'd23);
        o_cmd.elapsed = i_in.payload.elapsed_seconds;
        o_cmd.mjd     = i_in.payload.set_mjd;
        o_cmd.hours   = hours_sat[4:0];
        o_cmd.minutes = bcd_sat(i_in.payload.set_minutes_bcd, 6'd59);
        o_cmd.seconds = bcd_sat(i_in.payload.set_seconds_bcd, 6'd59);
    end
endmodule
`default_nettype wire

@@ hdl/ucld_queue.sv @@
// Short command queue between front end and back end.
`default_nettype none
module ucld_queue #(
    parameter int unsigned Depth = ucld_pkg::QueueDepth
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ucld_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output ucld_pkg::t_cmd      o_cmd,
    output logic                o_empty
);
    import ucld_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] Full    = CntW'(Depth);

    t_cmd            r_mem [Depth];
    logic [PtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == Full);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LastPtr) ? '0 : r_wptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LastPtr) ? '0 : r_rptr + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

@@ hdl/ucld_back.sv @@
// Back end: clock state, MJD to date conversion, zone offset, result register.
`default_nettype none
module ucld_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [5:0]     i_cfg_wdata,
    input  wire ucld_pkg::t_cmd i_cmd,
    input  wire logic           i_empty,
    output logic                o_pop,
    ucld_out_if.source          o_out
);
    import ucld_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_DATE = 3'd3;
    localparam logic [2:0] ST_OFS  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_zone;
    logic        r_set, n_set;
    logic [15:0] r_mjd, n_mjd;
    logic [4:0]  r_hours, n_hours;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;

    logic [15:0] r_d;
    logic [32:0] r_prod;
    logic [16:0] r_wx;
    logic [34:0] r_wprod;
    logic [5:0]  r_q;
    logic [10:0] r_rem;
    logic [2:0]  r_wd;
    t_date       r_date;

    logic        r_out_valid;
    t_out_item   r_out;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;
    assign o_pop         = (r_state == ST_IDLE) && !i_empty;

    // Clock update on a popped command.
    logic [8:0]  tot;
    logic [2:0]  cmin;
    logic [6:0]  m2;
    always_comb begin
        n_set   = r_set;
        n_mjd   = r_mjd;
        n_hours = r_hours;
        n_min   = r_min;
        n_sec   = r_sec;
        tot     = 9'(r_sec) + 9'(i_cmd.elapsed);
        if (tot >= 9'd300)      cmin = 3'd5;
        else if (tot >= 9'd240) cmin = 3'd4;
        else if (tot >= 9'd180) cmin = 3'd3;
        else if (tot >= 9'd120) cmin = 3'd2;
        else if (tot >= 9'd60)  cmin = 3'd1;
        else                    cmin = 3'd0;
        m2 = 7'(r_min) + 7'(cmin);
        if (o_pop) begin
            case (i_cmd.op)
                OP_TICK: begin
                    if (r_set) begin
                        n_sec = 6'(tot - 9'(cmin) * 9'd60);
                        if (m2 >= 7'd60) begin
                            n_min = 6'(m2 - 7'd60);
                            if (r_hours >= 5'd23) begin
                                n_hours = 5'd0;
                                n_mjd   = r_mjd + 16'd1;
                            end else begin
                                n_hours = r_hours + 5'd1;
                            end
                        end else begin
                            n_min = m2[5:0];
                        end
                    end
                end
                OP_SET: begin
                    n_set   = 1'b1;
                    n_mjd   = i_cmd.mjd;
                    n_hours = i_cmd.hours;
                    n_min   = i_cmd.minutes;
                    n_sec   = i_cmd.seconds;
                end
                default: ;
            endcase
        end
    end

    // Date pieces.
    logic [15:0] mjd_c;
    logic [5:0]  q_n;
    logic [1:0]  yy;
    logic [8:0]  doy;
    logic [11:0] ybase;
    logic [3:0]  mi;
    t_date       n_date;
    always_comb begin
        mjd_c = (r_mjd < MjdFloor) ? MjdFloor : r_mjd;
        q_n   = r_prod[QuadShift +: 6];
        if (r_rem >= 11'd1095)     yy = 2'd3;
        else if (r_rem >= 11'd730) yy = 2'd2;
        else if (r_rem >= 11'd365) yy = 2'd1;
        else                       yy = 2'd0;
        doy   = 9'(r_rem - 11'(yy) * 11'd365);
        ybase = BaseYear + 12'({r_q, 2'b00}) + 12'(yy);
        mi    = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (doy >= month_start(4'(i))) mi = 4'(i);
        end
        n_date.wd  = r_wd;
        n_date.day = 5'(doy - month_start(mi) + 9'd1);
        if (mi >= 4'd10) begin
            n_date.month = mi - 4'd9;
            n_date.year  = ybase + 12'd1;
        end else begin
            n_date.month = mi + 4'd3;
            n_date.year  = ybase;
        end
    end

    // Zone offset: minutes first, then hours.
    t_date            od;
    logic signed [7:0] smi, sh;
    logic [5:0]       mag;
    logic             pos;
    t_out_item        res;
    always_comb begin
        od  = r_date;
        smi = 8'(r_min);
        sh  = 8'(r_hours);
        pos = r_zone > ZoneUtc;
        mag = pos ? r_zone - ZoneUtc : ZoneUtc - r_zone;
        if (r_zone != ZoneUtc) begin
            if (mag[0]) begin
                smi = pos ? smi + 8'sd30 : smi - 8'sd30;
            end
            if (smi >= 8'sd60) begin
                smi = smi - 8'sd60;
                sh  = sh + 8'sd1;
                if (sh >= 8'sd24) begin
                    sh = sh - 8'sd24;
                    od = day_fwd(od);
                end
            end else if (smi < 8'sd0) begin
                smi = smi + 8'sd60;
                sh  = sh - 8'sd1;
                if (sh < 8'sd0) begin
                    sh = sh + 8'sd24;
                    od = day_bck(od);
                end
            end
            sh = pos ? sh + 8'(mag[5:1]) : sh - 8'(mag[5:1]);
            if (sh < 8'sd0) begin
                sh = sh + 8'sd24;
                od = day_bck(od);
            end else if (sh >= 8'sd24) begin
                sh = sh - 8'sd24;
                od = day_fwd(od);
            end
        end
        res.time_valid    = r_set;
        res.year          = od.year;
        res.month         = od.month;
        res.day           = od.day;
        res.weekday       = od.wd;
        res.local_hours   = sh[4:0];
        res.local_minutes = smi[5:0];
        res.clock_seconds = r_sec;
        if (!r_set) res = '0;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (!i_empty) n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  n_state = ST_DATE;
            ST_DATE: n_state = ST_OFS;
            ST_OFS:  if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_zone      <= ZoneUtc;
            r_set       <= 1'b0;
            r_mjd       <= '0;
            r_hours     <= '0;
            r_min       <= '0;
            r_sec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_zone <= i_cfg_wdata;
            r_set   <= n_set;
            r_mjd   <= n_mjd;
            r_hours <= n_hours;
            r_min   <= n_min;
            r_sec   <= n_sec;
            if (r_state == ST_OFS && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_d     <= mjd_c - MjdFloor;
            r_prod  <= 33'(mjd_c - MjdFloor) * 33'(QuadRecip);
            r_wx    <= 17'(r_mjd) + 17'd2;
            r_wprod <= 35'(17'(r_mjd) + 17'd2) * 35'(WeekRecip);
        end
        if (r_state == ST_DIV) begin
            r_q   <= q_n;
            r_rem <= 11'(r_d - 16'(q_n) * 16'(QuadDays));
            r_wd  <= 3'(r_wx - 17'(r_wprod[WeekShift +: 15]) * 17'd7) + 3'd1;
        end
        if (r_state == ST_DATE) begin
            r_date <= n_date;
        end
        if (r_state == ST_OFS && (!r_out_valid || o_out.ready)) begin
            r_out <= res;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.time_valid) |-> r_set)
        else $error("valid reading from an unset clock");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_min <= 6'd59) && (r_sec <= 6'd59) && (r_hours <= 5'd23))
        else $error("clock state out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.time_valid) |->
        (r_out.month >= 4'd1 && r_out.month <= 4'd12 && r_out.day != 5'd0))
        else $error("bad local date");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> (r_state != ST_IDLE || $past(r_state) == ST_OFS))
        else $error("sequencer left a command early");
endmodule
`default_nettype wire
